FILE: rtl/lccp_pkg.sv
// Shared types, constants and helper functions of the coefficient compress-and-pack block.
package lccp_pkg;

    // coefficients per polynomial
    localparam int COEFF_COUNT = 256;

    localparam int COEFF_W    = 13;
    localparam int CODE_W     = 11;
    localparam int WIDTH_W    = 4;
    localparam int SLOT_W     = 2;
    localparam int POS_W      = 11;
    localparam int BYTE_CNT_W = 9;
    localparam int ACC_W      = 18;   // 7 pending bits plus an 11-bit code
    localparam int ACC_CNT_W  = 5;
    localparam int PEND_W     = 7;
    localparam int PEND_CNT_W = 3;

    // operand and product widths of the compression multiplier
    localparam int OPND_W  = 25;
    localparam int MCON_W  = 21;
    localparam int PROD_W  = OPND_W + MCON_W + 1;
    localparam int KEEP_W  = 42;       // highest product bit ever used is 41

    localparam int TASK_Q_DEPTH = 4;
    localparam int TASK_Q_PTR_W = $clog2(TASK_Q_DEPTH);
    localparam int OUT_BUF_DEPTH = 2;
    localparam int OUT_BUF_PTR_W = $clog2(OUT_BUF_DEPTH);

    // supported compressed widths
    localparam logic [WIDTH_W-1:0] WIDTH_1  = 4'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_4  = 4'd4;
    localparam logic [WIDTH_W-1:0] WIDTH_5  = 4'd5;
    localparam logic [WIDTH_W-1:0] WIDTH_10 = 4'd10;
    localparam logic [WIDTH_W-1:0] WIDTH_11 = 4'd11;

    // configuration register indexes
    localparam logic CFG_BITS_PER_COEFF = 1'b0;
    localparam logic CFG_POLY_SLOT      = 1'b1;

    localparam logic signed [COEFF_W-1:0] MOD_Q = 13'sd3329;

    localparam logic signed [OPND_W-1:0] RND_HI = 25'sd1665;
    localparam logic signed [OPND_W-1:0] RND_LO = 25'sd1664;
    localparam logic [MCON_W-1:0] MUL_W4  = 21'd80635;
    localparam logic [MCON_W-1:0] MUL_W5  = 21'd40318;
    localparam logic [MCON_W-1:0] MUL_W10 = 21'd1290167;
    localparam logic [MCON_W-1:0] MUL_W11 = 21'd645084;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } t_task;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_out_word;

    function automatic logic [WIDTH_W-1:0] eff_width(logic [WIDTH_W-1:0] d);
        logic [WIDTH_W-1:0] w;
        case (d)
            WIDTH_1, WIDTH_4, WIDTH_5, WIDTH_10, WIDTH_11: w = d;
            default: w = WIDTH_4;
        endcase
        return w;
    endfunction

    // slot * ceil(d * COEFF_COUNT / 8), wrapped to the position width
    function automatic logic [POS_W-1:0] poly_base(logic [WIDTH_W-1:0] d,
                                                   logic [SLOT_W-1:0]  slot);
        logic [19:0] span;
        logic [19:0] per_poly;
        logic [21:0] base;
        span     = 20'(d) * 20'(COEFF_COUNT);
        per_poly = 20'(span + 20'd7) >> 3;
        base     = 22'(slot) * 22'(per_poly);
        return base[POS_W-1:0];
    endfunction

endpackage

FILE: rtl/lattice_coeff_compress_pack.sv
// Top level of the lattice coefficient compressor and byte packer.
//
// Usage: push one signed coefficient per word on the input queue port
// (push/full); a word is taken at a clock edge with push high and full low.
// Mark the final coefficient of a polynomial with i_coeff_last. Packed bytes
// come out of a queue-style port (empty/pop): while empty is low the oldest
// byte, its position in the vector and its last flag sit on the outputs, and
// pop at an edge with empty low takes it.
// Configuration (bits_per_coeff at index 0, poly_slot at index 1) is written
// through i_cfg_valid/o_cfg_ready; write it only while the block is idle.
// The edge that takes the word loads the first of the two front stages
// around the constant multiplier; the code then passes the second front
// stage and the task queue, and the packer writes its first byte into the
// output buffer, from where it can be popped.
// Throughput: the front takes one coefficient per cycle while full is low;
// the packer writes at most one byte per cycle while the output buffer has
// space, staying busy on a code for d of 10 or 11 and for a final flush byte.
// When the receiver stalls, the output buffer fills, the packer holds, the
// task queue fills and full rises; no word is dropped.
// Reset clears the pipeline, queues, bit accumulator and byte counter, and
// sets bits_per_coeff to 4 and poly_slot to 0.
module lattice_coeff_compress_pack (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [lccp_pkg::COEFF_W-1:0] i_coeff,
    input  logic                                i_coeff_last,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          o_out_byte,
    output logic [lccp_pkg::POS_W-1:0]          o_byte_position,
    output logic                                o_out_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [lccp_pkg::WIDTH_W-1:0]        i_cfg_data
);
    import lccp_pkg::*;

    logic [WIDTH_W-1:0] r_bits_per_coeff;
    logic [SLOT_W-1:0]  r_poly_slot;

    logic [WIDTH_W-1:0] width;
    logic [POS_W-1:0]   base;
    logic               q_push;
    logic               q_can_push;
    t_task              q_in;
    logic               q_valid;
    logic               q_pop;
    t_task              q_head;
    t_out_word          word;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_coeff <= WIDTH_4;
            r_poly_slot      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BITS_PER_COEFF: r_bits_per_coeff <= i_cfg_data;
                CFG_POLY_SLOT:      r_poly_slot      <= i_cfg_data[SLOT_W-1:0];
                default:            r_poly_slot      <= r_poly_slot;
            endcase
        end
    end

    // unsupported widths act as 4, also for the byte offset of the slot
    assign width = eff_width(r_bits_per_coeff);
    assign base  = poly_base(width, r_poly_slot);

    lccp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_coeff      (i_coeff),
        .i_coeff_last (i_coeff_last),
        .i_width      (width),
        .i_q_can_push (q_can_push),
        .o_q_push     (q_push),
        .o_q_task     (q_in)
    );

    lccp_task_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_task     (q_in),
        .o_can_push (q_can_push),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_task     (q_head)
    );

    lccp_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .i_task       (q_head),
        .o_task_pop   (q_pop),
        .i_base       (base),
        .pop          (pop),
        .empty        (empty),
        .o_word       (word)
    );

    assign o_out_byte      = word.data;
    assign o_byte_position = word.pos;
    assign o_out_last      = word.last;

endmodule

FILE: rtl/lccp_front.sv
// Front pipeline: map the coefficient, multiply by the width constant, extract the code.
module lccp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [lccp_pkg::COEFF_W-1:0] i_coeff,
    input  logic                              i_coeff_last,
    input  logic [lccp_pkg::WIDTH_W-1:0]      i_width,
    input  logic                              i_q_can_push,
    output logic                              o_q_push,
    output lccp_pkg::t_task                   o_q_task
);
    import lccp_pkg::*;

    logic signed [COEFF_W-1:0] x;
    logic signed [OPND_W-1:0]  xw;
    logic signed [OPND_W-1:0]  opnd;
    logic [MCON_W-1:0]         mcon;
    logic signed [PROD_W-1:0]  prod;
    logic [CODE_W-1:0]         code;
    logic                      adv;
    logic                      accept;

    logic                      r_s1_valid;
    logic signed [OPND_W-1:0]  r_s1_opnd;
    logic [MCON_W-1:0]         r_s1_mcon;
    logic [WIDTH_W-1:0]        r_s1_width;
    logic                      r_s1_last;

    logic                      r_s2_valid;
    logic [KEEP_W-1:0]         r_s2_prod;
    logic [WIDTH_W-1:0]        r_s2_width;
    logic                      r_s2_last;

    // add q to negative coefficients and build the multiplier operand
    always_comb begin
        x  = i_coeff[COEFF_W-1] ? i_coeff + MOD_Q : i_coeff;
        xw = {{(OPND_W-COEFF_W){x[COEFF_W-1]}}, x};
        case (i_width)
            WIDTH_1: begin
                opnd = (xw <<< 1) + RND_HI;
                mcon = MUL_W4;
            end
            WIDTH_5: begin
                opnd = (xw <<< 5) + RND_LO;
                mcon = MUL_W5;
            end
            WIDTH_10: begin
                opnd = (xw <<< 10) + RND_HI;
                mcon = MUL_W10;
            end
            WIDTH_11: begin
                opnd = (xw <<< 11) + RND_LO;
                mcon = MUL_W11;
            end
            default: begin
                opnd = (xw <<< 4) + RND_HI;
                mcon = MUL_W4;
            end
        endcase
    end

    assign prod = r_s1_opnd * $signed({1'b0, r_s1_mcon});

    always_comb begin
        case (r_s2_width)
            WIDTH_1:  code = CODE_W'(r_s2_prod[28]);
            WIDTH_5:  code = CODE_W'(r_s2_prod[31:27]);
            WIDTH_10: code = CODE_W'(r_s2_prod[41:32]);
            WIDTH_11: code = r_s2_prod[41:31];
            default:  code = CODE_W'(r_s2_prod[31:28]);
        endcase
    end

    // the whole pipe advances unless the last stage is held by a full queue
    assign adv    = !r_s2_valid || i_q_can_push;
    assign full   = !adv;
    assign accept = push && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_opnd  <= opnd;
            r_s1_mcon  <= mcon;
            r_s1_width <= i_width;
            r_s1_last  <= i_coeff_last;
            r_s2_prod  <= prod[KEEP_W-1:0];
            r_s2_width <= r_s1_width;
            r_s2_last  <= r_s1_last;
        end
    end

    assign o_q_push       = r_s2_valid && i_q_can_push;
    assign o_q_task.code  = code;
    assign o_q_task.width = r_s2_width;
    assign o_q_task.last  = r_s2_last;

endmodule

FILE: rtl/lccp_task_queue.sv
// Short queue of compressed codes between the front pipeline and the packer.
module lccp_task_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lccp_pkg::t_task i_task,
    output logic            o_can_push,
    input  logic            i_pop,
    output logic            o_valid,
    output lccp_pkg::t_task o_task
);
    import lccp_pkg::*;

    t_task                   r_mem [TASK_Q_DEPTH];
    logic [TASK_Q_PTR_W-1:0] r_wr_ptr;
    logic [TASK_Q_PTR_W-1:0] r_rd_ptr;
    logic [TASK_Q_PTR_W:0]   r_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_can_push = r_count != (TASK_Q_PTR_W+1)'(TASK_Q_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_task     = r_mem[r_rd_ptr];
    assign do_push    = i_push && o_can_push;
    assign do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

endmodule

FILE: rtl/lccp_packer.sv
// Back end: pack codes into bytes, at most one byte per cycle while there is space, into a small output buffer.
module lccp_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_task_valid,
    input  lccp_pkg::t_task                i_task,
    output logic                           o_task_pop,
    input  logic [lccp_pkg::POS_W-1:0]     i_base,
    input  logic                           pop,
    output logic                           empty,
    output lccp_pkg::t_out_word            o_word
);
    import lccp_pkg::*;

    logic [ACC_W-1:0]      cur_acc;
    logic [ACC_CNT_W-1:0]  cur_cnt;
    logic                  cur_last;
    logic                  have;
    logic                  emit;
    logic                  fin;
    logic                  step;
    logic                  more;
    logic [ACC_W-1:0]      rem_acc;
    logic [ACC_CNT_W-1:0]  rem_cnt;
    logic                  ob_space;
    logic                  ob_push;
    logic                  ob_pop;
    t_out_word             new_word;

    logic                  r_busy;
    logic [ACC_W-1:0]      r_acc;
    logic [ACC_CNT_W-1:0]  r_cnt;
    logic                  r_last;
    logic [PEND_W-1:0]     r_pend_bits;
    logic [PEND_CNT_W-1:0] r_pend_cnt;
    logic [BYTE_CNT_W-1:0] r_byte_cnt;

    t_out_word              r_ob [OUT_BUF_DEPTH];
    logic [OUT_BUF_PTR_W-1:0] r_ob_wr;
    logic [OUT_BUF_PTR_W-1:0] r_ob_rd;
    logic [OUT_BUF_PTR_W:0]   r_ob_count;

    // merge a fresh code into the pending bits, or keep draining the held word
    always_comb begin
        have = r_busy || i_task_valid;
        if (r_busy) begin
            cur_acc  = r_acc;
            cur_cnt  = r_cnt;
            cur_last = r_last;
        end else begin
            cur_acc  = ACC_W'(r_pend_bits) | (ACC_W'(i_task.code) << r_pend_cnt);
            cur_cnt  = ACC_CNT_W'(r_pend_cnt) + ACC_CNT_W'(i_task.width);
            cur_last = i_task.last;
        end
        emit    = have && (cur_cnt >= ACC_CNT_W'(8) || (cur_last && cur_cnt != '0));
        fin     = cur_last && cur_cnt <= ACC_CNT_W'(8);
        step    = have && (!emit || ob_space);
        rem_acc = emit ? (cur_acc >> 8) : cur_acc;
        if (!emit) begin
            rem_cnt = cur_cnt;
        end else if (cur_cnt >= ACC_CNT_W'(8)) begin
            rem_cnt = cur_cnt - ACC_CNT_W'(8);
        end else begin
            rem_cnt = '0;
        end
        more = rem_cnt >= ACC_CNT_W'(8) || (cur_last && rem_cnt != '0);
    end

    assign o_task_pop    = !r_busy && i_task_valid && step;
    assign new_word.data = cur_acc[7:0];
    assign new_word.pos  = i_base + POS_W'(r_byte_cnt);
    assign new_word.last = fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_byte_cnt  <= '0;
        end else if (step) begin
            if (more) begin
                r_busy <= 1'b1;
            end else begin
                r_busy <= 1'b0;
                if (cur_last) begin
                    r_pend_bits <= '0;
                    r_pend_cnt  <= '0;
                end else begin
                    r_pend_bits <= rem_acc[PEND_W-1:0];
                    r_pend_cnt  <= rem_cnt[PEND_CNT_W-1:0];
                end
            end
            if (emit) begin
                r_byte_cnt <= fin ? '0 : r_byte_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && more) begin
            r_acc  <= rem_acc;
            r_cnt  <= rem_cnt;
            r_last <= cur_last;
        end
    end

    // output buffer
    assign ob_space = r_ob_count != (OUT_BUF_PTR_W+1)'(OUT_BUF_DEPTH);
    assign ob_push  = step && emit;
    assign ob_pop   = pop && !empty;
    assign empty    = r_ob_count == '0;
    assign o_word   = r_ob[r_ob_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr    <= '0;
            r_ob_rd    <= '0;
            r_ob_count <= '0;
        end else begin
            if (ob_push) begin
                r_ob_wr <= r_ob_wr + 1'b1;
            end
            if (ob_pop) begin
                r_ob_rd <= r_ob_rd + 1'b1;
            end
            if (ob_push && !ob_pop) begin
                r_ob_count <= r_ob_count + 1'b1;
            end else if (ob_pop && !ob_push) begin
                r_ob_count <= r_ob_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_ob_wr] <= new_word;
        end
    end

endmodule
